### rtl/lpcp_pkg.sv
package lpcp_pkg;

  // Point coordinate width default (signed Q.8 metres)
  localparam int COORD_WIDTH_DEF = 24;

  // Fixed-point scaling
  localparam int ROT_FRAC       = 14;
  localparam int HEIGHT_OFFSET  = 512;
  localparam int HEIGHT_SHIFT   = 11;
  localparam int LEVEL_MAX      = 255;

  // Divider depth: pixel quotient bits, depth level bits
  localparam int DIV_STEPS      = 16;
  localparam int DEPTH_STEPS    = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X = 3'd0,
    CFG_ROW_Y = 3'd1,
    CFG_ROW_Z = 3'd2,
    CFG_FOCAL = 3'd3,
    CFG_IMAGE = 3'd4,
    CFG_RANGE = 3'd5
  } cfg_idx_t;

  // Reset values
  localparam logic [63:0] ROW_X_RST = 64'd16384;
  localparam logic [63:0] ROW_Y_RST = 64'd1073741824;
  localparam logic [63:0] ROW_Z_RST = 64'd70368744177664;
  localparam logic [63:0] FOCAL_RST = 64'd2432009770526326400;
  localparam logic [31:0] IMAGE_RST = 32'd70780800;
  localparam logic [15:0] RANGE_RST = 16'd25600;

  // Live configuration handed to the datapath
  typedef struct packed {
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
    logic [63:0] focal;
    logic [31:0] image;
    logic [15:0] range;
  } cfg_t;

endpackage

### rtl/lpcp_if.sv
interface lpcp_in_if #(parameter int CW = lpcp_pkg::COORD_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpcp_out_if;
  logic        valid;
  logic        ready;
  logic        in_view;
  logic [15:0] pixel_col;
  logic [15:0] pixel_row;
  logic [7:0]  height_level;
  logic [7:0]  depth_level;
  modport source (output valid, in_view, pixel_col, pixel_row, height_level, depth_level,
                  input ready);
  modport sink   (input valid, in_view, pixel_col, pixel_row, height_level, depth_level,
                  output ready);
endinterface

interface lpcp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lpcp_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/lpcp_xform.sv
module lpcp_xform #(
  parameter int COORD_WIDTH = lpcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [COORD_WIDTH-1:0] pt_x,
  input  logic signed [COORD_WIDTH-1:0] pt_y,
  input  logic signed [COORD_WIDTH-1:0] pt_z,
  input  lpcp_pkg::cfg_t                cfg,
  output logic                          out_vld,
  output logic signed [COORD_WIDTH+4:0] xc,
  output logic signed [COORD_WIDTH+4:0] yc,
  output logic signed [COORD_WIDTH+4:0] zc
);
  import lpcp_pkg::*;

  localparam int PW   = COORD_WIDTH + 16;
  localparam int ACCW = COORD_WIDTH + 19;
  localparam int CAMW = ACCW - ROT_FRAC;

  logic [63:0]            row [0:2];
  logic signed [COORD_WIDTH-1:0] pt [0:2];
  logic                   vld1_r, vld2_r;
  logic signed [PW-1:0]   prod_r [0:2][0:2];
  logic signed [ACCW-1:0] acc_nxt [0:2];
  logic signed [CAMW-1:0] cam_r [0:2];

  assign row[0] = cfg.row_x;
  assign row[1] = cfg.row_y;
  assign row[2] = cfg.row_z;
  assign pt[0]  = pt_x;
  assign pt[1]  = pt_y;
  assign pt[2]  = pt_z;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  // stage 1: nine rotation products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= PW'($signed(row[r][16*c +: 16]) * pt[c]);
        end
      end
    end
  end

  // stage 2: row sums plus translation, floor back to Q.8
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = ACCW'(prod_r[r][0]) + ACCW'(prod_r[r][1]) + ACCW'(prod_r[r][2])
                 + (ACCW'($signed(row[r][63:48])) <<< ROT_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        cam_r[r] <= acc_nxt[r][ACCW-1:ROT_FRAC];
      end
    end
  end

  assign out_vld = vld2_r;
  assign xc      = cam_r[0];
  assign yc      = cam_r[1];
  assign zc      = cam_r[2];

  property p_fill;
    @(posedge clk) disable iff (!rst_n) (en && in_vld) |=> vld1_r;
  endproperty
  a_fill: assert property (p_fill) else $error("xform stage 1 lost a request");

  property p_hold;
    @(posedge clk) disable iff (!rst_n) !en |=> $stable(vld2_r) && $stable(vld1_r);
  endproperty
  a_hold: assert property (p_hold) else $error("xform advanced during stall");

  property p_chain;
    @(posedge clk) disable iff (!rst_n) (en && vld1_r) |=> vld2_r;
  endproperty
  a_chain: assert property (p_chain) else $error("xform stage 2 lost a request");

endmodule

### rtl/lpcp_proj.sv
module lpcp_proj #(
  parameter int COORD_WIDTH = lpcp_pkg::COORD_WIDTH_DEF,
  localparam int CAMW = COORD_WIDTH + 5,
  localparam int NW   = CAMW + 18,
  localparam int DW   = CAMW + 3,
  localparam int ZW   = CAMW + 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [CAMW-1:0] xc,
  input  logic signed [CAMW-1:0] yc,
  input  logic signed [CAMW-1:0] zc,
  input  lpcp_pkg::cfg_t         cfg,
  output logic                   out_vld,
  output logic                   ok,
  output logic [NW-1:0]          num_u,
  output logic [NW-1:0]          num_v,
  output logic [DW-1:0]          den,
  output logic [ZW-1:0]          num_z,
  output logic [15:0]            rng,
  output logic                   dsat,
  output logic [7:0]             hl
);
  import lpcp_pkg::*;

  localparam int TW = CAMW + 1;
  localparam int MW = CAMW + 9;

  logic                 vld3_r, vld4_r;
  logic signed [NW-1:0] nu3_r, nv3_r;
  logic signed [CAMW-1:0] zc3_r;
  logic                 zpos3_r;
  logic [7:0]           hl3_r, hl4_r;
  logic signed [ZW-1:0] zn3_r;
  logic signed [TW-1:0] ht;
  logic signed [MW-1:0] hm, hs;
  logic [7:0]           hl_nxt;
  logic [15:0]          rng_nxt;
  logic [DW-1:0]        den_nxt;
  logic signed [NW:0]   sden;
  logic                 badu, badv;
  logic                 ok4_r, dsat4_r;
  logic [NW-1:0]        nu4_r, nv4_r;
  logic [DW-1:0]        den4_r;
  logic [ZW-1:0]        zn4_r;
  logic [15:0]          rng4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld3_r <= in_vld;
      vld4_r <= vld3_r;
    end
  end

  // height level: (512 - yc) * 255 / 2048, clamped
  always_comb begin
    ht = TW'(HEIGHT_OFFSET) - TW'(yc);
    hm = MW'(ht) * MW'(LEVEL_MAX);
    hs = hm >>> HEIGHT_SHIFT;
    if (ht <= 0)                hl_nxt = 8'd0;
    else if (hs > MW'(LEVEL_MAX)) hl_nxt = 8'(LEVEL_MAX);
    else                        hl_nxt = hs[7:0];
  end

  // stage 3: projection numerators and depth numerator
  always_ff @(posedge clk) begin
    if (en) begin
      nu3_r   <= NW'($signed({1'b0, cfg.focal[15:0]}) * xc)
               + NW'($signed({1'b0, cfg.focal[47:32]}) * zc);
      nv3_r   <= NW'($signed({1'b0, cfg.focal[31:16]}) * yc)
               + NW'($signed({1'b0, cfg.focal[63:48]}) * zc);
      zc3_r   <= zc;
      zpos3_r <= (zc > 0);
      hl3_r   <= hl_nxt;
      zn3_r   <= ZW'(zc) * ZW'(LEVEL_MAX);
    end
  end

  // stage 4: range pre-checks so the quotients fit in their bits
  always_comb begin
    den_nxt = {zc3_r[CAMW-2:0], 4'b0000};
    sden    = $signed({{(NW+1-DW){1'b0}}, den_nxt});
    if (nu3_r[NW-1]) badu = !((NW+1)'(nu3_r) + sden > 0);
    else             badu = ((NW+1)'(nu3_r >>> DIV_STEPS) >= sden);
    if (nv3_r[NW-1]) badv = !((NW+1)'(nv3_r) + sden > 0);
    else             badv = ((NW+1)'(nv3_r >>> DIV_STEPS) >= sden);
    rng_nxt = (cfg.range == 16'd0) ? 16'd1 : cfg.range;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok4_r   <= zpos3_r && !badu && !badv;
      nu4_r   <= nu3_r[NW-1] ? '0 : nu3_r;
      nv4_r   <= nv3_r[NW-1] ? '0 : nv3_r;
      den4_r  <= den_nxt;
      zn4_r   <= zn3_r;
      rng4_r  <= rng_nxt;
      dsat4_r <= (zn3_r >= $signed(ZW'({rng_nxt, 8'd0})));
      hl4_r   <= hl3_r;
    end
  end

  assign out_vld = vld4_r;
  assign ok      = ok4_r;
  assign num_u   = nu4_r;
  assign num_v   = nv4_r;
  assign den     = den4_r;
  assign num_z   = zn4_r;
  assign rng     = rng4_r;
  assign dsat    = dsat4_r;
  assign hl      = hl4_r;

  property p_nonpos;
    @(posedge clk) disable iff (!rst_n) (en && vld3_r && !zpos3_r) |=> !ok4_r;
  endproperty
  a_nonpos: assert property (p_nonpos) else $error("point behind camera marked usable");

  property p_den;
    @(posedge clk) disable iff (!rst_n) (vld4_r && ok4_r) |-> (den4_r != '0);
  endproperty
  a_den: assert property (p_den) else $error("zero divisor reached divider");

  property p_rng;
    @(posedge clk) disable iff (!rst_n) vld4_r |-> (rng4_r != 16'd0);
  endproperty
  a_rng: assert property (p_rng) else $error("zero range reached divider");

endmodule

### rtl/lpcp_div.sv
module lpcp_div #(
  parameter int NW = 47,
  parameter int DW = 32,
  parameter int ZW = 37
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic          ok,
  input  logic [NW-1:0] num_u,
  input  logic [NW-1:0] num_v,
  input  logic [DW-1:0] den,
  input  logic [ZW-1:0] num_z,
  input  logic [15:0]   rng,
  input  logic          dsat,
  input  logic [7:0]    hl,
  output logic          out_vld,
  output logic          out_ok,
  output logic [15:0]   q_u,
  output logic [15:0]   q_v,
  output logic [7:0]    q_hl,
  output logic [7:0]    q_dl
);
  import lpcp_pkg::*;

  localparam int NS = DIV_STEPS;
  localparam int DS = DEPTH_STEPS;

  // stage chain: index 0 is the divider input, index NS its last stage
  wire          c_vld  [0:NS];
  wire          c_ok   [0:NS];
  wire          c_sat  [0:NS];
  wire [NW-1:0] c_ru   [0:NS];
  wire [NW-1:0] c_rv   [0:NS];
  wire [DW-1:0] c_den  [0:NS];
  wire [ZW-1:0] c_rz   [0:NS];
  wire [15:0]   c_rng  [0:NS];
  wire [15:0]   c_qu   [0:NS];
  wire [15:0]   c_qv   [0:NS];
  wire [7:0]    c_qz   [0:NS];
  wire [7:0]    c_hl   [0:NS];

  assign c_vld[0] = in_vld;
  assign c_ok[0]  = ok;
  assign c_sat[0] = dsat;
  assign c_ru[0]  = num_u;
  assign c_rv[0]  = num_v;
  assign c_den[0] = den;
  assign c_rz[0]  = num_z;
  assign c_rng[0] = rng;
  assign c_qu[0]  = '0;
  assign c_qv[0]  = '0;
  assign c_qz[0]  = '0;
  assign c_hl[0]  = hl;

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    localparam int I = NS - k;
    logic          vld_r, ok_r, sat_r;
    logic [NW-1:0] ru_r, rv_r;
    logic [DW-1:0] den_r;
    logic [ZW-1:0] rz_r;
    logic [15:0]   rng_r, qu_r, qv_r;
    logic [7:0]    qz_r, hl_r;
    logic [NW:0]   su, sv;
    logic [ZW:0]   sz;
    logic [NW-1:0] ru_nxt, rv_nxt;
    logic [ZW-1:0] rz_nxt;
    logic [7:0]    qz_nxt;

    // one restoring step per quotient bit; depth uses the last steps only
    always_comb begin
      su = {1'b0, c_ru[k-1]} - ((NW+1)'(c_den[k-1]) << I);
      sv = {1'b0, c_rv[k-1]} - ((NW+1)'(c_den[k-1]) << I);
      sz = {1'b0, c_rz[k-1]} - ((ZW+1)'(c_rng[k-1]) << (I % DS));
      ru_nxt = su[NW] ? c_ru[k-1] : su[NW-1:0];
      rv_nxt = sv[NW] ? c_rv[k-1] : sv[NW-1:0];
      if (I < DS) begin
        rz_nxt = sz[ZW] ? c_rz[k-1] : sz[ZW-1:0];
        qz_nxt = {c_qz[k-1][6:0], !sz[ZW]};
      end else begin
        rz_nxt = c_rz[k-1];
        qz_nxt = c_qz[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r <= 1'b0;
      else if (en) vld_r <= c_vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ok_r  <= c_ok[k-1];
        sat_r <= c_sat[k-1];
        ru_r  <= ru_nxt;
        rv_r  <= rv_nxt;
        den_r <= c_den[k-1];
        rz_r  <= rz_nxt;
        rng_r <= c_rng[k-1];
        qu_r  <= {c_qu[k-1][14:0], !su[NW]};
        qv_r  <= {c_qv[k-1][14:0], !sv[NW]};
        qz_r  <= qz_nxt;
        hl_r  <= c_hl[k-1];
      end
    end

    assign c_vld[k] = vld_r;
    assign c_ok[k]  = ok_r;
    assign c_sat[k] = sat_r;
    assign c_ru[k]  = ru_r;
    assign c_rv[k]  = rv_r;
    assign c_den[k] = den_r;
    assign c_rz[k]  = rz_r;
    assign c_rng[k] = rng_r;
    assign c_qu[k]  = qu_r;
    assign c_qv[k]  = qv_r;
    assign c_qz[k]  = qz_r;
    assign c_hl[k]  = hl_r;
  end

  assign out_vld = c_vld[NS];
  assign out_ok  = c_ok[NS];
  assign q_u     = c_qu[NS];
  assign q_v     = c_qv[NS];
  assign q_hl    = c_hl[NS];
  assign q_dl    = c_sat[NS] ? 8'(LEVEL_MAX) : c_qz[NS];

  property p_first;
    @(posedge clk) disable iff (!rst_n) (en && in_vld) |=> c_vld[1];
  endproperty
  a_first: assert property (p_first) else $error("divider dropped a request");

  property p_last;
    @(posedge clk) disable iff (!rst_n) !en |=> $stable(c_vld[NS]);
  endproperty
  a_last: assert property (p_last) else $error("divider moved during stall");

  property p_rem;
    @(posedge clk) disable iff (!rst_n)
      (c_vld[NS] && c_ok[NS]) |-> (c_ru[NS] < NW'(c_den[NS]));
  endproperty
  a_rem: assert property (p_rem) else $error("column remainder not below divisor");

endmodule

### rtl/lidar_point_camera_projection_top.sv
// Channel | Dir | Handshake        | Payload
// in_ch   | in  | valid / ready    | point_x, point_y, point_z (signed Q.8)
// out_ch  | out | valid / ready    | in_view, pixel_col, pixel_row, height_level, depth_level
// cfg_ch  | in  | valid / ready=1  | index (register number), data
//
// One point enters per cycle while no held result is waiting to be taken.
// The 21 register stages are the 16-step restoring divider for the pixel quotients
// plus four transform/projection stages and the output register.
// Reset (rst_n low, synchronous) clears all valid bits and loads the default
// configuration. A stalled output freezes every stage together; nothing is lost.
module lidar_point_camera_projection_top #(
  parameter int COORD_WIDTH = lpcp_pkg::COORD_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lpcp_in_if.sink    in_ch,
  lpcp_out_if.source out_ch,
  lpcp_cfg_if.sink   cfg_ch
);
  import lpcp_pkg::*;

  localparam int CAMW = COORD_WIDTH + 5;
  localparam int NW   = CAMW + 18;
  localparam int DW   = CAMW + 3;
  localparam int ZW   = CAMW + 8;

  cfg_t cfg_r;
  logic en;

  logic                   x_vld;
  logic signed [CAMW-1:0] xc, yc, zc;
  logic                   p_vld, p_ok, p_dsat;
  logic [NW-1:0]          p_nu, p_nv;
  logic [DW-1:0]          p_den;
  logic [ZW-1:0]          p_nz;
  logic [15:0]            p_rng;
  logic [7:0]             p_hl;
  logic                   d_vld, d_ok;
  logic [15:0]            d_qu, d_qv;
  logic [7:0]             d_hl, d_dl;

  logic        out_vld_r, view_r, view_nxt;
  logic [15:0] col_r, row_r;
  logic [7:0]  hl_r, dl_r;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_x <= ROW_X_RST;
      cfg_r.row_y <= ROW_Y_RST;
      cfg_r.row_z <= ROW_Z_RST;
      cfg_r.focal <= FOCAL_RST;
      cfg_r.image <= IMAGE_RST;
      cfg_r.range <= RANGE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_ROW_X: cfg_r.row_x <= cfg_ch.data;
        CFG_ROW_Y: cfg_r.row_y <= cfg_ch.data;
        CFG_ROW_Z: cfg_r.row_z <= cfg_ch.data;
        CFG_FOCAL: cfg_r.focal <= cfg_ch.data;
        CFG_IMAGE: cfg_r.image <= cfg_ch.data[31:0];
        CFG_RANGE: cfg_r.range <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a held result is not taken
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  lpcp_xform #(.COORD_WIDTH(COORD_WIDTH)) u_xform (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_ch.valid),
    .pt_x(in_ch.point_x), .pt_y(in_ch.point_y), .pt_z(in_ch.point_z),
    .cfg(cfg_r), .out_vld(x_vld), .xc(xc), .yc(yc), .zc(zc)
  );

  lpcp_proj #(.COORD_WIDTH(COORD_WIDTH)) u_proj (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(x_vld),
    .xc(xc), .yc(yc), .zc(zc), .cfg(cfg_r),
    .out_vld(p_vld), .ok(p_ok), .num_u(p_nu), .num_v(p_nv), .den(p_den),
    .num_z(p_nz), .rng(p_rng), .dsat(p_dsat), .hl(p_hl)
  );

  lpcp_div #(.NW(NW), .DW(DW), .ZW(ZW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(p_vld), .ok(p_ok),
    .num_u(p_nu), .num_v(p_nv), .den(p_den), .num_z(p_nz), .rng(p_rng),
    .dsat(p_dsat), .hl(p_hl),
    .out_vld(d_vld), .out_ok(d_ok), .q_u(d_qu), .q_v(d_qv), .q_hl(d_hl), .q_dl(d_dl)
  );

  // image bounds test and output register
  assign view_nxt = d_ok && (d_qu < cfg_r.image[15:0]) && (d_qv < cfg_r.image[31:16]);

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= d_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      view_r <= view_nxt;
      col_r  <= view_nxt ? d_qu : 16'd0;
      row_r  <= view_nxt ? d_qv : 16'd0;
      hl_r   <= view_nxt ? d_hl : 8'd0;
      dl_r   <= view_nxt ? d_dl : 8'd0;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.in_view      = view_r;
  assign out_ch.pixel_col    = col_r;
  assign out_ch.pixel_row    = row_r;
  assign out_ch.height_level = hl_r;
  assign out_ch.depth_level  = dl_r;

  property p_zero;
    @(posedge clk) disable iff (!rst_n)
      (out_vld_r && !view_r) |-> (col_r == 16'd0 && row_r == 16'd0 && hl_r == 8'd0
                                  && dl_r == 8'd0);
  endproperty
  a_zero: assert property (p_zero) else $error("out-of-view result carries data");

  property p_bounds;
    @(posedge clk) disable iff (!rst_n)
      (out_vld_r && view_r) |-> (col_r < cfg_r.image[15:0] && row_r < cfg_r.image[31:16]);
  endproperty
  a_bounds: assert property (p_bounds) else $error("in-view pixel outside image");

  property p_load;
    @(posedge clk) disable iff (!rst_n) (en && d_vld) |=> out_vld_r;
  endproperty
  a_load: assert property (p_load) else $error("output register missed a result");

endmodule

### sim/tb_lidar_point_camera_projection_top.sv
module tb_lidar_point_camera_projection_top;
  import lpcp_pkg::*;

  localparam int CW = 24;
  localparam int LATENCY = 21;

  logic clk;
  logic rst_n;

  lpcp_in_if #(.CW(CW)) in_ch ();
  lpcp_out_if           out_ch ();
  lpcp_cfg_if           cfg_ch ();

  lidar_point_camera_projection_top #(.COORD_WIDTH(CW)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  typedef struct packed {
    logic        in_view;
    logic [15:0] pixel_col;
    logic [15:0] pixel_row;
    logic [7:0]  height_level;
    logic [7:0]  depth_level;
  } pixel_res_t;

  // Shadow copy of the register file
  logic [63:0] row_x_q, row_y_q, row_z_q, focal_q;
  logic [31:0] image_q;
  logic [15:0] range_q;

  pixel_res_t pixel_q[$];
  int         err_cnt;
  int         pts_sent;
  int         res_seen;
  int         view_cnt;
  int         src_idle_pct;
  int         snk_idle_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Limit on run length
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $display("timeout: %0d requests sent, %0d results seen", pts_sent, res_seen);
    $finish;
  end

  // Camera coordinate of one transform row, floored to Q.8
  function automatic longint cam_axis(logic [63:0] row, longint x, longint y, longint z);
    longint acc;
    acc = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
        + longint'($signed(row[47:32])) * z
        + longint'($signed(row[63:48])) * (longint'(1) << ROT_FRAC);
    return acc >>> ROT_FRAC;
  endfunction

  function automatic pixel_res_t project_point(logic [CW-1:0] px, logic [CW-1:0] py,
                                               logic [CW-1:0] pz);
    pixel_res_t r;
    longint x, y, z, xc, yc, zc, u, v, hl, dl, rng;
    x  = longint'($signed(px));
    y  = longint'($signed(py));
    z  = longint'($signed(pz));
    xc = cam_axis(row_x_q, x, y, z);
    yc = cam_axis(row_y_q, x, y, z);
    zc = cam_axis(row_z_q, x, y, z);
    r  = '0;
    if (zc <= 0) return r;
    // SV division truncates toward zero like C
    u = (longint'(focal_q[15:0]) * xc + longint'(focal_q[47:32]) * zc) / (16 * zc);
    v = (longint'(focal_q[31:16]) * yc + longint'(focal_q[63:48]) * zc) / (16 * zc);
    if (u < 0 || u >= longint'(image_q[15:0]) || v < 0 || v >= longint'(image_q[31:16]))
      return r;
    hl = (512 - yc) * 255;
    hl = (hl <= 0) ? 0 : hl / 2048;
    if (hl > 255) hl = 255;
    rng = (range_q == 0) ? 1 : longint'(range_q);
    dl = zc * 255 / rng;
    if (dl > 255) dl = 255;
    r.in_view      = 1'b1;
    r.pixel_col    = u[15:0];
    r.pixel_row    = v[15:0];
    r.height_level = hl[7:0];
    r.depth_level  = dl[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, exp_v, res_seen);
    err_cnt++;
  endtask

  // Result checker and receiver stalls
  initial begin
    pixel_res_t exp_r;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          exp_r = pixel_q.pop_front();
          if (out_ch.in_view !== exp_r.in_view)
            report_mismatch("in_view", out_ch.in_view, exp_r.in_view);
          if (out_ch.pixel_col !== exp_r.pixel_col)
            report_mismatch("pixel_col", out_ch.pixel_col, exp_r.pixel_col);
          if (out_ch.pixel_row !== exp_r.pixel_row)
            report_mismatch("pixel_row", out_ch.pixel_row, exp_r.pixel_row);
          if (out_ch.height_level !== exp_r.height_level)
            report_mismatch("height_level", out_ch.height_level, exp_r.height_level);
          if (out_ch.depth_level !== exp_r.depth_level)
            report_mismatch("depth_level", out_ch.depth_level, exp_r.depth_level);
          if (exp_r.in_view) view_cnt++;
        end
        res_seen++;
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Send one point request, holding valid until it is taken; valid stays up after
  // the handshake so the next request can follow without a gap
  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.point_z <= pz;
    pixel_q = {pixel_q, project_point(px, py, pz)};
    pts_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Wait until every expected result is in, then let the pipe drain
  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_ROW_X: row_x_q = val;
      CFG_ROW_Y: row_y_q = val;
      CFG_ROW_Z: row_z_q = val;
      CFG_FOCAL: focal_q = val;
      CFG_IMAGE: image_q = val[31:0];
      CFG_RANGE: range_q = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [63:0] pack_row(int rx, int ry, int rz, int t);
    logic [15:0] a, b, c, d;
    a = rx[15:0]; b = ry[15:0]; c = rz[15:0]; d = t[15:0];
    return {d, c, b, a};
  endfunction

  // Small random point in front of the camera, mostly projecting inside the image
  task automatic send_scene_point();
    int z, x, y;
    z = $urandom_range(60000, 50);
    x = $signed($urandom_range(2 * z)) - z;
    y = $signed($urandom_range(z)) - z / 2;
    send_point(x[CW-1:0], y[CW-1:0], z[CW-1:0]);
  endtask

  task automatic send_random_point();
    case ($urandom_range(3))
      0:       send_point(CW'($urandom), CW'($urandom), CW'($urandom));
      default: send_scene_point();
    endcase
  endtask

  // Directed: field extremes and special cases under the default setup
  task automatic test_directed();
    logic [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_point(CW'(0), CW'(0), CW'(0));              // zero depth
    send_point(CW'(0), CW'(0), CW'(-256));           // behind the camera
    send_point(CW'(0), CW'(0), CW'(1));              // tiny depth
    send_point(CW'(0), CW'(0), CW'(256));            // image centre
    send_point(mx, mx, mx);
    send_point(mn, mn, mn);
    send_point(mn, mx, mx);
    send_point(CW'(0), CW'(0), mx);                  // depth clamps at full level
    send_point(CW'(0), CW'(2560), CW'(2560));        // height below zero level, off the image bottom
    send_point(CW'(0), CW'(-2560), CW'(2560));       // height would clamp high, off the image top
    send_point(CW'(0), CW'(512), CW'(2560));         // height level exactly zero
    send_point(CW'(-2458), CW'(-1383), CW'(2560));   // near top-left corner
    send_point(CW'(2458), CW'(1383), CW'(2560));     // off the bottom-right edge
    send_point(CW'(2457), CW'(1382), CW'(2560));     // just inside the bottom-right corner
    send_point(CW'(-2459), CW'(0), CW'(2560));       // just left of the edge, truncates into column 0
    send_point(CW'(0), CW'(25600), CW'(256));        // far below the image
    send_point(CW'(-1), CW'(-1), CW'(255));          // negative floors
    send_point({CW{1'b1}}, CW'(0), CW'(300));
    drain_pipe();
  endtask

  // Every register at extreme values
  task automatic test_config_extremes();
    write_reg(CFG_ROW_X, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_ROW_Y, 64'h0);
    write_reg(CFG_ROW_Z, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(CFG_FOCAL, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_IMAGE, 64'hFFFF_FFFF);
    write_reg(CFG_RANGE, 64'h0);      // zero range behaves as one
    repeat (150) send_random_point();
    drain_pipe();
    write_reg(CFG_ROW_X, pack_row(-32768, 0, 0, -32768));
    write_reg(CFG_ROW_Y, pack_row(0, -32768, 0, 32767));
    write_reg(CFG_ROW_Z, pack_row(0, 0, -32768, -32768));
    write_reg(CFG_FOCAL, 64'h0);
    write_reg(CFG_IMAGE, 64'h1);
    write_reg(CFG_RANGE, 64'hFFFF);
    repeat (150) send_random_point();
    drain_pipe();
  endtask

  // Random rigid-ish transforms with random content
  task automatic test_random_config(int n_pts);
    write_reg(CFG_ROW_X, pack_row($urandom_range(20000) - 10000 + 16384,
                                  $urandom_range(8000) - 4000,
                                  $urandom_range(8000) - 4000, $urandom_range(2048) - 1024));
    write_reg(CFG_ROW_Y, pack_row($urandom_range(8000) - 4000,
                                  $urandom_range(20000) - 10000 + 16384,
                                  $urandom_range(8000) - 4000, $urandom_range(2048) - 1024));
    write_reg(CFG_ROW_Z, pack_row($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                                  $urandom_range(8000) + 12000, $urandom_range(2048) - 1024));
    write_reg(CFG_FOCAL, {16'($urandom_range(20000)), 16'($urandom_range(32000)),
                          16'($urandom_range(30000, 1000)), 16'($urandom_range(30000, 1000))});
    write_reg(CFG_IMAGE, 64'({16'($urandom_range(4000, 1)), 16'($urandom_range(4000, 1))}));
    write_reg(CFG_RANGE, 64'($urandom_range(65535, 1)));
    repeat (n_pts) send_random_point();
    drain_pipe();
  endtask

  // Default configuration stream, restoring reset values
  task automatic test_default_stream(int n_pts);
    write_reg(CFG_ROW_X, ROW_X_RST);
    write_reg(CFG_ROW_Y, ROW_Y_RST);
    write_reg(CFG_ROW_Z, ROW_Z_RST);
    write_reg(CFG_FOCAL, FOCAL_RST);
    write_reg(CFG_IMAGE, 64'(IMAGE_RST));
    write_reg(CFG_RANGE, 64'(RANGE_RST));
    repeat (n_pts) begin
      send_random_point();
      // sender holds off until the pipe is empty
      if ($urandom_range(99) == 0) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pixel_q.size() != 0);
      end
    end
    drain_pipe();
  endtask

  initial begin
    err_cnt = 0; pts_sent = 0; res_seen = 0; view_cnt = 0;
    src_idle_pct = 33; snk_idle_pct = 85;
    row_x_q = ROW_X_RST; row_y_q = ROW_Y_RST; row_z_q = ROW_Z_RST;
    focal_q = FOCAL_RST; image_q = IMAGE_RST; range_q = RANGE_RST;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.point_x = '0; in_ch.point_y = '0; in_ch.point_z = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_ROW_X; cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random_config(200);
    test_default_stream(250);
    src_idle_pct = 85; snk_idle_pct = 33;
    test_random_config(300);
    test_default_stream(250);
    src_idle_pct = 0; snk_idle_pct = 0;
    test_random_config(300);
    test_default_stream(400);
    test_random_config(100);

    $display("covered %0d points over reset, extreme and random configurations",
             pts_sent);
    $display("%0d results checked, %0d of them in view", res_seen, view_cnt);
    if (err_cnt == 0 && pixel_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/lpcp_pkg.sv
rtl/lpcp_if.sv
rtl/lpcp_xform.sv
rtl/lpcp_proj.sv
rtl/lpcp_div.sv
rtl/lidar_point_camera_projection_top.sv
sim/tb_lidar_point_camera_projection_top.sv
